FILE: rtl/tvsd_pkg.sv
package tvsd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned ERROR_W = 2;
    localparam int unsigned VALUE_W = 64;

    localparam logic [KIND_W-1:0] KIND_TRUE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FALSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUM   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SCHAR = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd5;

    localparam logic [ERROR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERROR_W-1:0] ERR_TAG  = 2'd1;
    localparam logic [ERROR_W-1:0] ERR_CHAR = 2'd2;

    localparam logic [7:0] TAG_T = 8'h74;
    localparam logic [7:0] TAG_F = 8'h66;
    localparam logic [7:0] TAG_S = 8'h73;
    localparam logic [7:0] TAG_I = 8'h69;
    localparam logic [7:0] TAG_L = 8'h6c;
    localparam logic [7:0] TAG_C = 8'h63;
    localparam logic [7:0] TAG_STRING = 8'h53;

    typedef enum logic [2:0] {
        CLASS_TRUE,
        CLASS_FALSE,
        CLASS_NUM,
        CLASS_STR,
        CLASS_CHAR,
        CLASS_UNKNOWN
    } tag_class_t;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_NUM_HEAD,
        PH_NUM_BODY,
        PH_CHAR,
        PH_LEN_HEAD,
        PH_LEN_BODY,
        PH_STR
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        tag_class_t tag;
    } item_t;

    typedef struct packed {
        logic valid;
    } queue_ctrl_t;

endpackage

FILE: rtl/tagged_value_stream_decoder.sv
// Channel   Ports                      Payload
// input     in_valid / in_stall        byte_in
// output    out_valid / out_stall      kind, value, last, error
//
// Sustains one byte per cycle while out_stall is low; each byte yields zero or one result.
// A result reaches the output register after its byte passes through the queue:
// the queue takes the byte when it is accepted, decode state and result register when it is taken.
// rst_n clears the queue, the decode state and the output valid at once.
// in_stall rises only when the input queue is full; out_stall holds a valid result in the result register.
module tagged_value_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = tvsd_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          byte_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tvsd_pkg::KIND_W-1:0]         kind,
    output logic signed [tvsd_pkg::VALUE_W-1:0] value,
    output logic                                last,
    output logic [tvsd_pkg::ERROR_W-1:0]        error
);

    tvsd_pkg::item_t       front_item;
    tvsd_pkg::item_t       back_item;
    tvsd_pkg::queue_ctrl_t queue_ctrl;
    logic                  queue_full;
    logic                  back_take;

    assign in_stall = queue_full;

    tvsd_front u_front (
        .byte_in (byte_in),
        .item    (front_item)
    );

    tvsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_item),
        .full      (queue_full),
        .ctrl_out  (queue_ctrl),
        .pop       (back_take),
        .pop_item  (back_item)
    );

    tvsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_ctrl (queue_ctrl),
        .item       (back_item),
        .take       (back_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value      (value),
        .last       (last),
        .error      (error)
    );

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error != tvsd_pkg::ERR_NONE) |-> last)
        else $error("error result without last");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error == tvsd_pkg::ERR_NONE) &&
        ((kind == tvsd_pkg::KIND_TRUE) || (kind == tvsd_pkg::KIND_FALSE) ||
         (kind == tvsd_pkg::KIND_EMPTY)) |-> (value == '0))
        else $error("flag result with nonzero value");

    a_char_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == tvsd_pkg::KIND_CHAR) || (kind == tvsd_pkg::KIND_SCHAR))
        |-> (value[63:8] == '0))
        else $error("character result wider than a byte");

endmodule

FILE: rtl/tvsd_front.sv
module tvsd_front (
    input  logic [7:0]     byte_in,
    output tvsd_pkg::item_t item
);

    always_comb
    begin
        item.data = byte_in;
        case (byte_in)
            tvsd_pkg::TAG_T:      item.tag = tvsd_pkg::CLASS_TRUE;
            tvsd_pkg::TAG_F:      item.tag = tvsd_pkg::CLASS_FALSE;
            tvsd_pkg::TAG_S,
            tvsd_pkg::TAG_I,
            tvsd_pkg::TAG_L:      item.tag = tvsd_pkg::CLASS_NUM;
            tvsd_pkg::TAG_STRING: item.tag = tvsd_pkg::CLASS_STR;
            tvsd_pkg::TAG_C:      item.tag = tvsd_pkg::CLASS_CHAR;
            default:              item.tag = tvsd_pkg::CLASS_UNKNOWN;
        endcase
    end

endmodule

FILE: rtl/tvsd_queue.sv
module tvsd_queue #(
    parameter int unsigned DEPTH = tvsd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tvsd_pkg::item_t       push_item,
    output logic                  full,
    output tvsd_pkg::queue_ctrl_t ctrl_out,
    input  logic                  pop,
    output tvsd_pkg::item_t       pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tvsd_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign full          = (count_reg == CNT_W'(DEPTH));
    assign do_push       = push && !full;
    assign do_pop        = pop && (count_reg != '0);
    assign ctrl_out.valid = (count_reg != '0);
    assign pop_item      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/tvsd_back.sv
module tvsd_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tvsd_pkg::queue_ctrl_t          queue_ctrl,
    input  tvsd_pkg::item_t                item,
    output logic                           take,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tvsd_pkg::KIND_W-1:0]    kind,
    output logic signed [tvsd_pkg::VALUE_W-1:0] value,
    output logic                           last,
    output logic [tvsd_pkg::ERROR_W-1:0]   error
);

    tvsd_pkg::phase_t phase_reg;
    tvsd_pkg::phase_t phase_next;

    logic [3:0]  bytes_left_reg;
    logic [3:0]  bytes_left_next;
    logic [3:0]  num_len_reg;
    logic [3:0]  num_len_next;
    logic        neg_reg;
    logic        neg_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] chars_left_reg;
    logic [31:0] chars_left_next;

    logic        out_valid_reg;
    logic [tvsd_pkg::KIND_W-1:0]  kind_reg;
    logic [63:0]                  value_reg;
    logic                         last_reg;
    logic [tvsd_pkg::ERROR_W-1:0] error_reg;

    logic                         res_valid;
    logic [tvsd_pkg::KIND_W-1:0]  res_kind;
    logic [63:0]                  res_value;
    logic                         res_last;
    logic [tvsd_pkg::ERROR_W-1:0] res_error;

    logic        num_done;
    logic        len_mode;
    logic        len_empty;
    logic        str_end;
    logic [63:0] finished;
    logic [7:0]  b;

    assign b    = item.data;
    assign take = queue_ctrl.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            tvsd_pkg::PH_NUM_HEAD,
            tvsd_pkg::PH_NUM_BODY:
            begin
                if (num_done)
                begin
                    phase_next = tvsd_pkg::PH_TAG;
                end
                else
                begin
                    phase_next = tvsd_pkg::PH_NUM_BODY;
                end
            end
            tvsd_pkg::PH_LEN_HEAD,
            tvsd_pkg::PH_LEN_BODY:
            begin
                if (!num_done)
                begin
                    phase_next = tvsd_pkg::PH_LEN_BODY;
                end
                else if (len_empty)
                begin
                    phase_next = tvsd_pkg::PH_TAG;
                end
                else
                begin
                    phase_next = tvsd_pkg::PH_STR;
                end
            end
            tvsd_pkg::PH_CHAR:
            begin
                phase_next = tvsd_pkg::PH_TAG;
            end
            tvsd_pkg::PH_STR:
            begin
                if (str_end)
                begin
                    phase_next = tvsd_pkg::PH_TAG;
                end
            end
            default:
            begin
                case (item.tag)
                    tvsd_pkg::CLASS_NUM:  phase_next = tvsd_pkg::PH_NUM_HEAD;
                    tvsd_pkg::CLASS_STR:  phase_next = tvsd_pkg::PH_LEN_HEAD;
                    tvsd_pkg::CLASS_CHAR: phase_next = tvsd_pkg::PH_CHAR;
                    default:              phase_next = tvsd_pkg::PH_TAG;
                endcase
            end
        endcase
    end

    always_comb
    begin
        acc_next        = acc_reg;
        num_len_next    = num_len_reg;
        neg_next        = neg_reg;
        bytes_left_next = bytes_left_reg;
        chars_left_next = chars_left_reg;
        res_valid       = 1'b0;
        res_kind        = tvsd_pkg::KIND_TRUE;
        res_value       = '0;
        res_last        = 1'b1;
        res_error       = tvsd_pkg::ERR_NONE;
        num_done        = 1'b0;
        len_mode        = 1'b0;
        len_empty       = 1'b0;
        str_end         = 1'b0;
        finished        = '0;
        case (phase_reg)
            tvsd_pkg::PH_NUM_HEAD,
            tvsd_pkg::PH_LEN_HEAD:
            begin
                neg_next        = b[3];
                num_len_next    = b[7:4];
                bytes_left_next = b[7:4];
                acc_next        = {60'd0, b[3:0]};
                num_done        = (b[7:4] == 4'd0);
                len_mode        = (phase_reg == tvsd_pkg::PH_LEN_HEAD);
            end
            tvsd_pkg::PH_NUM_BODY,
            tvsd_pkg::PH_LEN_BODY:
            begin
                acc_next        = {acc_reg[55:0], b};
                bytes_left_next = bytes_left_reg - 4'd1;
                num_done        = (bytes_left_next == 4'd0);
                len_mode        = (phase_reg == tvsd_pkg::PH_LEN_BODY);
            end
            tvsd_pkg::PH_CHAR:
            begin
                res_valid = 1'b1;
                res_kind  = tvsd_pkg::KIND_CHAR;
                res_value = {56'd0, b};
                res_error = b[7] ? tvsd_pkg::ERR_CHAR : tvsd_pkg::ERR_NONE;
            end
            tvsd_pkg::PH_STR:
            begin
                res_valid = 1'b1;
                res_kind  = tvsd_pkg::KIND_SCHAR;
                res_value = {56'd0, b};
                if (b[7])
                begin
                    chars_left_next = '0;
                    res_error       = tvsd_pkg::ERR_CHAR;
                    str_end         = 1'b1;
                end
                else
                begin
                    chars_left_next = chars_left_reg - 32'd1;
                    str_end         = (chars_left_next == 32'd0);
                    res_last        = str_end;
                end
            end
            default:
            begin
                case (item.tag)
                    tvsd_pkg::CLASS_TRUE:
                    begin
                        res_valid = 1'b1;
                        res_kind  = tvsd_pkg::KIND_TRUE;
                    end
                    tvsd_pkg::CLASS_FALSE:
                    begin
                        res_valid = 1'b1;
                        res_kind  = tvsd_pkg::KIND_FALSE;
                    end
                    tvsd_pkg::CLASS_UNKNOWN:
                    begin
                        res_valid = 1'b1;
                        res_kind  = tvsd_pkg::KIND_TRUE;
                        res_value = {56'd0, b};
                        res_error = tvsd_pkg::ERR_TAG;
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        endcase

        finished = acc_next;
        if (neg_next && !num_len_next[3])
        begin
            finished = acc_next | ({64{1'b1}} << {num_len_next[2:0], 3'b100});
        end

        if (num_done)
        begin
            if (len_mode)
            begin
                len_empty = (finished[31:0] == 32'd0) || finished[31];
                if (len_empty)
                begin
                    res_valid = 1'b1;
                    res_kind  = tvsd_pkg::KIND_EMPTY;
                end
                else
                begin
                    chars_left_next = finished[31:0];
                end
            end
            else
            begin
                res_valid = 1'b1;
                res_kind  = tvsd_pkg::KIND_NUM;
                res_value = finished;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tvsd_pkg::PH_TAG;
            bytes_left_reg <= '0;
            num_len_reg    <= '0;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            chars_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                num_len_reg    <= num_len_next;
                neg_reg        <= neg_next;
                acc_reg        <= acc_next;
                chars_left_reg <= chars_left_next;
                out_valid_reg  <= res_valid;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            kind_reg  <= res_kind;
            value_reg <= res_value;
            last_reg  <= res_last;
            error_reg <= res_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = $signed(value_reg);
    assign last      = last_reg;
    assign error     = error_reg;

endmodule
